>>> design/frx_pkg.sv
// Shared types, status codes, marker tables and the CRC-8 constants for the
// framed block receiver. No dependencies.
`default_nettype none

package frx_pkg;

  localparam int BLOCK_BYTES = 32;
  localparam int BIB_W       = $clog2(BLOCK_BYTES + 1);
  localparam int COUNT_W     = 16;
  localparam int START_LEN   = 7;
  localparam int END_LEN     = 5;
  localparam int MIDX_W      = 3;

  localparam logic [COUNT_W-1:0] BLOCK_TOTAL_RESET = 16'd2000;
  localparam logic [7:0]         CRC_POLY          = 8'h8C;

  typedef enum logic [2:0] {
    ST_MARKER     = 3'd0,
    ST_DATA       = 3'd1,
    ST_CHECK_OK   = 3'd2,
    ST_END_OK     = 3'd3,
    ST_MARKER_ERR = 3'd4,
    ST_CRC_ERR    = 3'd5,
    ST_IGNORED    = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_PAYLOAD = 5'b00010,
    PH_END     = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_byte;
    logic       is_check_byte;
    logic       payload_last;
  } result_t;

  // "[BEGIN]"
  function automatic logic [7:0] start_char(input logic [MIDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h5B;
      3'd1:    c = 8'h42;
      3'd2:    c = 8'h45;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h49;
      3'd5:    c = 8'h4E;
      3'd6:    c = 8'h5D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "[END]"
  function automatic logic [7:0] end_char(input logic [MIDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h5B;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h5D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/frx_crc8.sv
// Byte-wide update of the reflected CRC-8 (poly 0x8C), eight unrolled bit steps.
// Depends on frx_pkg.
`default_nettype none

module frx_crc8 (
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data_in,
  output logic      [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    logic       mix;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ data_in[k];
      c   = {1'b0, c[7:1]} ^ (mix ? frx_pkg::CRC_POLY : 8'h00);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

>>> design/frx_ctrl.sv
// Frame state, block counter, running CRC and per-byte result decode.
// Depends on frx_pkg and frx_crc8.
`default_nettype none

module frx_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire logic [7:0]                       rx_byte,
  input  wire logic                             cfg_we,
  input  wire logic [frx_pkg::COUNT_W-1:0]      cfg_wdata,
  output frx_pkg::result_t                      res
);

  frx_pkg::phase_t                    phase_r, phase_nxt;
  logic [frx_pkg::MIDX_W-1:0]         midx_r, midx_nxt;
  logic [frx_pkg::BIB_W-1:0]          bib_r, bib_nxt;
  logic [frx_pkg::COUNT_W-1:0]        blocks_done_r, blocks_done_nxt;
  logic [frx_pkg::COUNT_W-1:0]        block_total_r;
  logic [7:0]                         crc_r, crc_nxt;
  logic [7:0]                         crc_upd;
  logic [frx_pkg::COUNT_W-1:0]        count_inc;
  logic                               last_blk;

  frx_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign count_inc = blocks_done_r + frx_pkg::COUNT_W'(1);
  assign last_blk  = (count_inc == block_total_r);

  always_comb begin
    phase_nxt       = phase_r;
    midx_nxt        = midx_r;
    bib_nxt         = bib_r;
    blocks_done_nxt = blocks_done_r;
    crc_nxt         = crc_r;
    res             = '{status: frx_pkg::ST_IGNORED, data_byte: 8'h00,
                        is_check_byte: 1'b0, payload_last: 1'b0};
    unique case (phase_r)
      frx_pkg::PH_START: begin
        if (rx_byte == frx_pkg::start_char(midx_r)) begin
          res.status = frx_pkg::ST_MARKER;
          if (midx_r == frx_pkg::MIDX_W'(frx_pkg::START_LEN - 1)) begin
            phase_nxt       = frx_pkg::PH_PAYLOAD;
            midx_nxt        = '0;
            bib_nxt         = '0;
            blocks_done_nxt = '0;
            crc_nxt         = 8'h00;
          end else begin
            midx_nxt = midx_r + frx_pkg::MIDX_W'(1);
          end
        end else begin
          res.status = frx_pkg::ST_MARKER_ERR;
          phase_nxt  = frx_pkg::PH_ERROR;
        end
      end
      frx_pkg::PH_PAYLOAD: begin
        if (bib_r != frx_pkg::BIB_W'(frx_pkg::BLOCK_BYTES)) begin
          crc_nxt       = crc_upd;
          bib_nxt       = bib_r + frx_pkg::BIB_W'(1);
          res.status    = frx_pkg::ST_DATA;
          res.data_byte = rx_byte;
        end else begin
          res.is_check_byte = 1'b1;
          res.payload_last  = last_blk;
          if (rx_byte == crc_r) begin
            res.status      = frx_pkg::ST_CHECK_OK;
            res.data_byte   = rx_byte;
            blocks_done_nxt = count_inc;
            bib_nxt         = '0;
            crc_nxt         = 8'h00;
            if (last_blk) begin
              phase_nxt = frx_pkg::PH_END;
              midx_nxt  = '0;
            end
          end else begin
            res.status = frx_pkg::ST_CRC_ERR;
            phase_nxt  = frx_pkg::PH_ERROR;
          end
        end
      end
      frx_pkg::PH_END: begin
        if (rx_byte == frx_pkg::end_char(midx_r)) begin
          midx_nxt = midx_r + frx_pkg::MIDX_W'(1);
          if (midx_r == frx_pkg::MIDX_W'(frx_pkg::END_LEN - 1)) begin
            res.status = frx_pkg::ST_END_OK;
            phase_nxt  = frx_pkg::PH_DONE;
          end else begin
            res.status = frx_pkg::ST_MARKER;
          end
        end else begin
          res.status = frx_pkg::ST_MARKER_ERR;
          phase_nxt  = frx_pkg::PH_ERROR;
        end
      end
      frx_pkg::PH_DONE, frx_pkg::PH_ERROR: begin
        // terminal until reset
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= frx_pkg::PH_START;
      midx_r        <= '0;
      bib_r         <= '0;
      blocks_done_r <= '0;
      crc_r         <= 8'h00;
    end else if (step) begin
      phase_r       <= phase_nxt;
      midx_r        <= midx_nxt;
      bib_r         <= bib_nxt;
      blocks_done_r <= blocks_done_nxt;
      crc_r         <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_total_r <= frx_pkg::BLOCK_TOTAL_RESET;
    end else if (cfg_we) begin
      block_total_r <= cfg_wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_bib_range: assert property (@(posedge clk) disable iff (!rst_n)
    bib_r <= frx_pkg::BIB_W'(frx_pkg::BLOCK_BYTES))
    else $error("byte_in_block beyond block length");

  a_terminal_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == frx_pkg::PH_DONE || phase_r == frx_pkg::PH_ERROR)
      |-> res.status == frx_pkg::ST_IGNORED)
    else $error("terminal phase produced a non-ignored transaction");

  a_err_latches: assert property (@(posedge clk) disable iff (!rst_n)
    step && (res.status == frx_pkg::ST_MARKER_ERR || res.status == frx_pkg::ST_CRC_ERR)
      |=> phase_r == frx_pkg::PH_ERROR)
    else $error("error did not latch");

  a_last_is_check: assert property (@(posedge clk) disable iff (!rst_n)
    res.payload_last |-> res.is_check_byte)
    else $error("payload_last without check byte");

  a_crc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.status == frx_pkg::ST_CHECK_OK |=> crc_r == 8'h00 && bib_r == '0)
    else $error("CRC or byte count not cleared at block start");
`endif

endmodule

`default_nettype wire

>>> design/framed_block_crc8_receiver_unit.sv
// Framed block receiver: expects "[BEGIN]", then block_total blocks of 32 data
// bytes plus one reflected CRC-8 (poly 0x8C, init 0) check byte, then "[END]".
// One result transaction per input byte. Throughput is one byte per clock while
// out_stall is low; the byte is held in the input register and its result is
// registered in the output register when it advances. The CRC update is one
// unrolled byte step between the two registers. cfg_wdata is written when
// cfg_we is high and takes effect once registered; write it only while idle.
// After an error or a complete end marker every byte reports "ignored" until
// reset. Depends on frx_pkg and frx_ctrl.
`default_nettype none

module framed_block_crc8_receiver_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_status,
  output logic [7:0]                        out_data_byte,
  output logic                              out_is_check_byte,
  output logic                              out_payload_last,
  input  wire logic                         cfg_we,
  input  wire logic [frx_pkg::COUNT_W-1:0]  cfg_wdata
);

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             out_valid_r;
  frx_pkg::result_t out_res_r;
  frx_pkg::result_t res;
  logic             advance;

  // move the buffered byte into the result register
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  frx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_data_byte     = out_res_r.data_byte;
  assign out_is_check_byte = out_res_r.is_check_byte;
  assign out_payload_last  = out_res_r.payload_last;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for framed_block_crc8_receiver_unit: marker, block and CRC checks.
// Drives one frame of CRC-8 blocks, predicts every result and compares it.
// Depends on frx_pkg and the receiver RTL.

module tb_top;
  import frx_pkg::*;

  localparam int TOTAL_BLOCKS = 27;
  localparam int HOLD_CYCLES  = 60;
  localparam logic [8*START_LEN-1:0] START_TEXT = "[BEGIN]";
  localparam logic [8*END_LEN-1:0]   END_TEXT   = "[END]";

  typedef enum int {END_CLEAN, END_BAD_CHECK, END_BAD_MARKER} frame_end_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_status;
  logic [7:0]           out_data_byte;
  logic                 out_is_check_byte;
  logic                 out_payload_last;
  logic                 cfg_we;
  logic [COUNT_W-1:0]   cfg_wdata;

  // receiver state as predicted
  phase_t               rx_phase;
  logic [MIDX_W-1:0]    rx_mark_idx;
  logic [BIB_W-1:0]     rx_byte_cnt;
  logic [COUNT_W-1:0]   rx_blocks;
  logic [COUNT_W-1:0]   rx_total;
  logic [7:0]           rx_crc;

  result_t              results_due[$];
  logic [7:0]           block_lead[$];
  int                   mismatch_count = 0;
  int                   send_idle_pct  = 8;
  int                   recv_stall_pct = 60;
  int                   hold_requests  = 0;

  framed_block_crc8_receiver_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_data_byte     (out_data_byte),
    .out_is_check_byte (out_is_check_byte),
    .out_payload_last  (out_payload_last),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] start_byte(input int i);
    return START_TEXT[8*(START_LEN-1-i) +: 8];
  endfunction

  function automatic logic [7:0] end_byte(input int i);
    return END_TEXT[8*(END_LEN-1-i) +: 8];
  endfunction

  // reflected CRC-8, LSB of the data byte first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    int         k;
    c = crc;
    for (k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function result_t predict_rx_byte(input logic [7:0] b);
    result_t            r;
    logic [COUNT_W-1:0] next_count;
    r.status        = ST_IGNORED;
    r.data_byte     = 8'h00;
    r.is_check_byte = 1'b0;
    r.payload_last  = 1'b0;
    case (rx_phase)
      PH_START: begin
        if (b == start_byte(int'(rx_mark_idx))) begin
          r.status = ST_MARKER;
          if (rx_mark_idx == MIDX_W'(START_LEN - 1)) begin
            rx_phase    = PH_PAYLOAD;
            rx_mark_idx = '0;
            rx_byte_cnt = '0;
            rx_blocks   = '0;
            rx_crc      = 8'h00;
          end else begin
            rx_mark_idx = rx_mark_idx + MIDX_W'(1);
          end
        end else begin
          r.status = ST_MARKER_ERR;
          rx_phase = PH_ERROR;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte_cnt < BIB_W'(BLOCK_BYTES)) begin
          rx_crc      = crc8_step(rx_crc, b);
          rx_byte_cnt = rx_byte_cnt + BIB_W'(1);
          r.status    = ST_DATA;
          r.data_byte = b;
        end else begin
          // count wraps at 16 bits, so a total of 0 means 65536 blocks
          next_count      = rx_blocks + COUNT_W'(1);
          r.is_check_byte = 1'b1;
          r.payload_last  = (next_count == rx_total);
          if (b == rx_crc) begin
            r.status    = ST_CHECK_OK;
            r.data_byte = b;
            rx_blocks   = next_count;
            rx_byte_cnt = '0;
            rx_crc      = 8'h00;
            if (r.payload_last) begin
              rx_phase    = PH_END;
              rx_mark_idx = '0;
            end
          end else begin
            r.status = ST_CRC_ERR;
            rx_phase = PH_ERROR;
          end
        end
      end
      PH_END: begin
        if (b == end_byte(int'(rx_mark_idx))) begin
          rx_mark_idx = rx_mark_idx + MIDX_W'(1);
          if (rx_mark_idx == MIDX_W'(END_LEN)) begin
            r.status = ST_END_OK;
            rx_phase = PH_DONE;
          end else begin
            r.status = ST_MARKER;
          end
        end else begin
          r.status = ST_MARKER_ERR;
          rx_phase = PH_ERROR;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // result check first, then prediction: a byte accepted now has its result later
  always @(posedge clk) begin : rx_monitor
    result_t due;
    if (!rst_n) begin
      rx_phase    = PH_START;
      rx_mark_idx = '0;
      rx_byte_cnt = '0;
      rx_blocks   = '0;
      rx_total    = BLOCK_TOTAL_RESET;
      rx_crc      = 8'h00;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d data %02h chk %0b last %0b",
                     out_status, out_data_byte, out_is_check_byte, out_payload_last);
        end else begin
          due = results_due.pop_front();
          if (out_status !== due.status || out_data_byte !== due.data_byte ||
              out_is_check_byte !== due.is_check_byte ||
              out_payload_last !== due.payload_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp status %0d data %02h chk %0b last %0b, got %0d %02h %0b %0b",
                       due.status, due.data_byte, due.is_check_byte, due.payload_last,
                       out_status, out_data_byte, out_is_check_byte, out_payload_last);
          end
        end
      end
      if (cfg_we) rx_total = cfg_wdata;
      if (in_valid && !in_stall) results_due.push_back(predict_rx_byte(in_rx_byte));
    end
  end

  // result side: random stall plus long hold-offs on request
  initial begin : stall_gen
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   = 1'b0;
      in_rx_byte = 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  task write_block_total(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // 32 data bytes then the check byte; leading bytes come from block_lead
  task send_block(input bit corrupt);
    logic [7:0] crc;
    logic [7:0] b;
    logic [7:0] flip;
    int         i;
    crc = 8'h00;
    for (i = 0; i < BLOCK_BYTES; i++) begin
      if (block_lead.size() != 0) begin
        b = block_lead.pop_front();
      end else begin
        case ($urandom_range(15))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          2:       b = start_byte(0);
          default: b = 8'($urandom_range(255));
        endcase
      end
      crc = crc8_step(crc, b);
      send_byte(b);
    end
    if (corrupt) begin
      flip = 8'($urandom_range(1, 255));
      crc  = crc ^ flip;
    end
    send_byte(crc);
  endtask

  task test_block_total_extremes();
    write_block_total(16'd0);
    write_block_total(16'hFFFF);
  endtask

  task test_start_marker();
    int i;
    for (i = 0; i < START_LEN; i++) send_byte(start_byte(i));
  endtask

  task test_directed_block();
    block_lead = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h5B, 8'h5D, 8'hAA, 8'h55, 8'h7F, 8'hFE};
    send_block(1'b0);
  endtask

  // total already reached by the count: payload must carry on
  task test_count_below_done();
    wait_results_drained();
    write_block_total(16'd1);
  endtask

  task test_random_blocks();
    int blk;
    for (blk = 2; blk < TOTAL_BLOCKS; blk++) begin
      if (blk <= 9) begin
        send_idle_pct  = 8;
        recv_stall_pct = 60;
      end else if (blk <= 17) begin
        send_idle_pct  = 60;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (blk == 8 || blk == 22) hold_requests++;
      if (blk == 15) wait_results_drained();
      if (blk == 6 || blk == 12 || blk == 20) begin
        wait_results_drained();
        if (blk == 6) write_block_total(16'd0);
        else if (blk == 12) write_block_total(16'hFFFF);
        else write_block_total(COUNT_W'($urandom_range(1, blk - 1)));
      end
      send_block(1'b0);
    end
  endtask

  task test_frame_ending();
    frame_end_t how;
    int         i;
    int         bad_pos;
    logic [7:0] flip;
    case ($urandom_range(3))
      0, 1:    how = END_CLEAN;
      2:       how = END_BAD_CHECK;
      default: how = END_BAD_MARKER;
    endcase
    send_idle_pct  = 8;
    recv_stall_pct = 30;
    wait_results_drained();
    write_block_total(COUNT_W'(TOTAL_BLOCKS));
    send_block(how == END_BAD_CHECK);
    if (how == END_CLEAN) begin
      for (i = 0; i < END_LEN; i++) send_byte(end_byte(i));
    end else if (how == END_BAD_MARKER) begin
      bad_pos = $urandom_range(END_LEN - 1);
      for (i = 0; i < bad_pos; i++) send_byte(end_byte(i));
      flip = 8'($urandom_range(1, 255));
      send_byte(end_byte(bad_pos) ^ flip);
    end
  endtask

  // once done or failed, nothing restarts the frame, not even a new start marker
  task test_ignored_after_end();
    int i;
    for (i = 0; i < 30; i++) send_byte(8'($urandom_range(255)));
    for (i = 0; i < START_LEN; i++) send_byte(start_byte(i));
  endtask

  initial begin : run_tests
    int guard;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_block_total_extremes();
    test_start_marker();
    test_directed_block();
    test_count_below_done();
    test_random_blocks();
    test_frame_ending();
    test_ignored_after_end();

    @(negedge clk);
    in_valid = 1'b0;
    for (guard = 0; guard < 10000 && results_due.size() != 0; guard++) @(negedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> framed_block_crc8_receiver_unit.f
design/frx_pkg.sv
design/frx_crc8.sv
design/frx_ctrl.sv
design/framed_block_crc8_receiver_unit.sv
verif/tb_top.sv
